[rtl/core/tiled_3d_address_generator_unit_assert.svh]
// assertion macros used by the address generator checker
`ifndef TILED_3D_ADDRESS_GENERATOR_UNIT_ASSERT_SVH
`define TILED_3D_ADDRESS_GENERATOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while reset is asserted
`define TAGU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TAGU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/tagu_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and helpers of the tiled 3d address generator
package tagu_pkg;

	localparam int MAX_EXTENT        = 1024;
	localparam int MAX_ELEMENT_BYTES = 16;

	localparam int CNT_W  = 11;
	localparam int EB_W   = 5;
	localparam int CRD_W  = 10;
	localparam int IDX_W  = 30;
	localparam int OFS_W  = 34;
	localparam int CIDX_W = 3;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_CHUNK_ZERO = 3'd1,
		ST_EXT_SMALL  = 3'd2,
		ST_ELEM_ZERO  = 3'd3,
		ST_DONE       = 3'd4
	} status_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_X_EXTENT     = 3'd0,
		CFG_X_CHUNK      = 3'd1,
		CFG_Y_EXTENT     = 3'd2,
		CFG_Y_CHUNK      = 3'd3,
		CFG_Z_EXTENT     = 3'd4,
		CFG_Z_CHUNK      = 3'd5,
		CFG_ELEMENT_BYTES = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic accept;
		logic restart;
		logic mul1;
		logic mul2;
		logic sum;
		logic load;
	} tagu_cmd_t;

	function automatic logic [CNT_W-1:0] clamp_ext(input logic [CNT_W-1:0] v);
		return (v > CNT_W'(MAX_EXTENT)) ? CNT_W'(MAX_EXTENT) : v;
	endfunction

	function automatic logic [EB_W-1:0] clamp_eb(input logic [EB_W-1:0] v);
		return (v > EB_W'(MAX_ELEMENT_BYTES)) ? EB_W'(MAX_ELEMENT_BYTES) : v;
	endfunction

endpackage

[rtl/core/tagu_ctrl.sv]
`timescale 1ns / 1ps
// sequencer: accepts one item, walks it through the datapath, owns output valid
module tagu_ctrl
	import tagu_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      restart,
	output logic      out_valid,
	input  logic      out_ready,
	output tagu_cmd_t cmd
);

	typedef enum logic [2:0] {
		IDLE,
		MUL1,
		MUL2,
		SUM,
		LOAD
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.accept  = (state_q == IDLE) && in_valid;
		cmd.restart = restart;
		cmd.mul1    = (state_q == MUL1);
		cmd.mul2    = (state_q == MUL2);
		cmd.sum     = (state_q == SUM);
		// output register frees up in the same cycle it is taken
		cmd.load    = (state_q == LOAD) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) state_q <= MUL1;
				end
				MUL1: state_q <= MUL2;
				MUL2: state_q <= SUM;
				SUM:  state_q <= LOAD;
				LOAD: begin
					if (!out_valid_q || out_ready) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase

			if (cmd.load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

[rtl/core/tagu_datapath.sv]
`timescale 1ns / 1ps
// config registers, traversal counters, index arithmetic and output register
module tagu_datapath
	import tagu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  tagu_cmd_t         cmd,
	input  logic              cfg_valid,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]  cfg_data,
	output logic [IDX_W-1:0]  element_index,
	output logic [OFS_W-1:0]  byte_offset,
	output logic              in_domain,
	output logic              last_element,
	output logic [2:0]        status
);

	// config, stored already clamped
	logic [CNT_W-1:0] xe_q, xc_q, ye_q, yc_q, ze_q, zc_q;
	logic [EB_W-1:0]  eb_q;

	// traversal state
	logic [CNT_W-1:0] org_x_q, org_y_q, org_z_q;
	logic [CNT_W-1:0] ofs_x_q, ofs_y_q, ofs_z_q;
	logic             done_q;

	// per-item pipeline
	logic [CRD_W-1:0]   x_s1, y_s1, z_s1;
	logic               inside_s1, last_s1;
	status_t            status_s1;
	logic [20:0]        yx_s2, zx_s2;
	logic [IDX_W-1:0]   zxy_s3;
	logic [20:0]        xy_s3;
	logic [IDX_W-1:0]   idx_s4;

	// output register
	logic [IDX_W-1:0] element_index_q;
	logic [OFS_W-1:0] byte_offset_q;
	logic             in_domain_q, last_q;
	status_t          status_q;

	// effective state after an optional restart
	logic [CNT_W-1:0] e_ox, e_oy, e_oz, e_fx, e_fy, e_fz;
	logic             e_done;
	status_t          st_c;
	logic [CNT_W:0]   x_c, y_c, z_c;
	logic             inside_c;
	logic             wz, wy, wx, woz, woy, wox;
	logic [CNT_W:0]   nfz, nfy, nfx, noz, noy, nox;
	logic [34:0]      ofs_prod;
	logic [31:0]      zxy_prod;

	always_comb begin
		e_ox   = cmd.restart ? '0 : org_x_q;
		e_oy   = cmd.restart ? '0 : org_y_q;
		e_oz   = cmd.restart ? '0 : org_z_q;
		e_fx   = cmd.restart ? '0 : ofs_x_q;
		e_fy   = cmd.restart ? '0 : ofs_y_q;
		e_fz   = cmd.restart ? '0 : ofs_z_q;
		e_done = cmd.restart ? 1'b0 : done_q;

		priority if (xc_q == '0 || yc_q == '0 || zc_q == '0) st_c = ST_CHUNK_ZERO;
		else if (xe_q < xc_q || ye_q < yc_q || ze_q < zc_q) st_c = ST_EXT_SMALL;
		else if (eb_q == '0) st_c = ST_ELEM_ZERO;
		else if (e_done) st_c = ST_DONE;
		else st_c = ST_OK;

		x_c = {1'b0, e_ox} + {1'b0, e_fx};
		y_c = {1'b0, e_oy} + {1'b0, e_fy};
		z_c = {1'b0, e_oz} + {1'b0, e_fz};
		inside_c = (x_c < {1'b0, xe_q}) && (y_c < {1'b0, ye_q}) && (z_c < {1'b0, ze_q});

		// wrap tests of all six counters in parallel, then chained by enables
		nfz = {1'b0, e_fz} + (CNT_W+1)'(1);
		nfy = {1'b0, e_fy} + (CNT_W+1)'(1);
		nfx = {1'b0, e_fx} + (CNT_W+1)'(1);
		noz = {1'b0, e_oz} + {1'b0, zc_q};
		noy = {1'b0, e_oy} + {1'b0, yc_q};
		nox = {1'b0, e_ox} + {1'b0, xc_q};
		wz  = nfz >= {1'b0, zc_q};
		wy  = nfy >= {1'b0, yc_q};
		wx  = nfx >= {1'b0, xc_q};
		woz = noz >= {1'b0, ze_q};
		woy = noy >= {1'b0, ye_q};
		wox = nox >= {1'b0, xe_q};

		zxy_prod = 32'(zx_s2) * 32'(ye_q);
		ofs_prod = {5'b0, idx_s4} * {30'b0, eb_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xe_q    <= CNT_W'(1);
			xc_q    <= CNT_W'(1);
			ye_q    <= CNT_W'(1);
			yc_q    <= CNT_W'(1);
			ze_q    <= CNT_W'(1);
			zc_q    <= CNT_W'(1);
			eb_q    <= EB_W'(1);
			org_x_q <= '0;
			org_y_q <= '0;
			org_z_q <= '0;
			ofs_x_q <= '0;
			ofs_y_q <= '0;
			ofs_z_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_X_EXTENT:      xe_q <= clamp_ext(cfg_data);
					CFG_X_CHUNK:       xc_q <= clamp_ext(cfg_data);
					CFG_Y_EXTENT:      ye_q <= clamp_ext(cfg_data);
					CFG_Y_CHUNK:       yc_q <= clamp_ext(cfg_data);
					CFG_Z_EXTENT:      ze_q <= clamp_ext(cfg_data);
					CFG_Z_CHUNK:       zc_q <= clamp_ext(cfg_data);
					CFG_ELEMENT_BYTES: eb_q <= clamp_eb(cfg_data[EB_W-1:0]);
					default: ;
				endcase
			end

			if (cmd.accept) begin
				// start from the effective state; counters move only on a good item
				org_x_q <= e_ox;
				org_y_q <= e_oy;
				org_z_q <= e_oz;
				ofs_x_q <= e_fx;
				ofs_y_q <= e_fy;
				ofs_z_q <= e_fz;
				done_q  <= e_done;
				if (st_c == ST_OK) begin
					ofs_z_q <= wz ? '0 : nfz[CNT_W-1:0];
					if (wz) ofs_y_q <= wy ? '0 : nfy[CNT_W-1:0];
					if (wz && wy) ofs_x_q <= wx ? '0 : nfx[CNT_W-1:0];
					if (wz && wy && wx) org_z_q <= woz ? '0 : noz[CNT_W-1:0];
					if (wz && wy && wx && woz) org_y_q <= woy ? '0 : noy[CNT_W-1:0];
					if (wz && wy && wx && woz && woy) org_x_q <= wox ? '0 : nox[CNT_W-1:0];
					if (wz && wy && wx && woz && woy && wox) done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			// coordinates below an extent of at most 1024 fit ten bits
			x_s1      <= (st_c == ST_OK && inside_c) ? x_c[CRD_W-1:0] : '0;
			y_s1      <= (st_c == ST_OK && inside_c) ? y_c[CRD_W-1:0] : '0;
			z_s1      <= (st_c == ST_OK && inside_c) ? z_c[CRD_W-1:0] : '0;
			inside_s1 <= (st_c == ST_OK) && inside_c;
			last_s1   <= (st_c == ST_OK) && wz && wy && wx && woz && woy && wox;
			status_s1 <= st_c;
		end
		if (cmd.mul1) begin
			yx_s2 <= 21'(y_s1) * 21'(xe_q);
			zx_s2 <= 21'(z_s1) * 21'(xe_q);
		end
		if (cmd.mul2) begin
			zxy_s3 <= zxy_prod[IDX_W-1:0];
			xy_s3  <= 21'(x_s1) + yx_s2;
		end
		if (cmd.sum) begin
			idx_s4 <= zxy_s3 + IDX_W'(xy_s3);
		end
		if (cmd.load) begin
			element_index_q <= idx_s4;
			byte_offset_q   <= ofs_prod[OFS_W-1:0];
			in_domain_q     <= inside_s1;
			last_q          <= last_s1;
			status_q        <= status_s1;
		end
	end

	assign element_index = element_index_q;
	assign byte_offset   = byte_offset_q;
	assign in_domain     = in_domain_q;
	assign last_element  = last_q;
	assign status        = status_q;

endmodule

[rtl/core/tiled_3d_address_generator_unit.sv]
`timescale 1ns / 1ps
// Tiled 3d address generator: each accepted item (restart or next) yields one result with the
// linear element index, byte offset, domain flag, last flag and status of the next element in
// chunked traversal order. An item passes through the IDLE (accept), MUL1, MUL2, SUM and LOAD
// states: the acceptance step steps the six counters and checks parameters, MUL1 forms y*xe
// and z*xe, MUL2 forms z*xe*ye and adds x to y*xe, SUM adds the terms, and LOAD multiplies by
// the element size into the output register. The sequencer handles one item at a time and
// takes no new item until the last one is loaded; a held result stalls the next load.
// Configuration writes are always ready and take effect at once; config registers reset to 1.
module tiled_3d_address_generator_unit
	import tagu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              restart,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [IDX_W-1:0]  element_index,
	output logic [OFS_W-1:0]  byte_offset,
	output logic              in_domain,
	output logic              last_element,
	output logic [2:0]        status,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CNT_W-1:0]  cfg_data
);

	tagu_cmd_t cmd;

	assign cfg_ready = 1'b1;

	tagu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.restart   (restart),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	tagu_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.element_index (element_index),
		.byte_offset   (byte_offset),
		.in_domain     (in_domain),
		.last_element  (last_element),
		.status        (status)
	);

endmodule

[rtl/core/tagu_checker.sv]
`timescale 1ns / 1ps
// port-level checker of the address generator, bound to the top level
`include "tiled_3d_address_generator_unit_assert.svh"

module tagu_checker
	import tagu_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [IDX_W-1:0]  element_index,
	input logic [OFS_W-1:0]  byte_offset,
	input logic              in_domain,
	input logic              last_element,
	input logic [2:0]        status
);

	`TAGU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	`TAGU_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")

	`TAGU_ASSERT_NOW(a_err_zero, out_valid && status != ST_OK, element_index == '0 && byte_offset == '0 && !in_domain && !last_element, "error result carries data")

	`TAGU_ASSERT_NOW(a_outside_zero, out_valid && !in_domain, element_index == '0 && byte_offset == '0, "element outside domain has an address")

endmodule

bind tiled_3d_address_generator_unit tagu_checker u_tagu_checker (.*);
